FILE: sv/ptc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the pressure/temperature compensation core.
// No dependencies.
package ptc_pkg;

  localparam int RawW       = 20;
  localparam int TempW      = 16;
  localparam int PressW     = 25;
  localparam int WordW      = 64;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;

  localparam logic [RawW-1:0]   NoSampleMark = 20'h80000;
  localparam logic [PressW-1:0] PressMax     = 25'h1FFFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_COEFFS = 2'd0,
    REG_PRESS_LOW   = 2'd1,
    REG_PRESS_HIGH  = 2'd2,
    REG_PRESS_LAST  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
  } coeffs_t;

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    return {{(WordW-16){v[15]}}, v};
  endfunction

endpackage

FILE: sv/ptc_front.sv
`timescale 1ns / 1ps
// Input side: takes sample beats and drops those that carry the no-sample marker.
// Depends on ptc_pkg.
module ptc_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ptc_pkg::RawW-1:0] raw_pressure_i,
  input  logic [ptc_pkg::RawW-1:0] raw_temperature_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output ptc_pkg::sample_t         q_data_o
);
  import ptc_pkg::*;

  // Stall only on a full queue; marker beats are accepted and dropped.
  assign in_stall_o = q_full_i;
  assign q_data_o   = '{raw_pressure: raw_pressure_i, raw_temperature: raw_temperature_i};
  assign q_push_o   = in_valid_i && !q_full_i &&
                      (raw_pressure_i != NoSampleMark) && (raw_temperature_i != NoSampleMark);
endmodule

FILE: sv/ptc_queue.sv
`timescale 1ns / 1ps
// Short FIFO that decouples the front from the compute back end.
// Depends on ptc_pkg.
module ptc_queue #(
  parameter int Depth = ptc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ptc_pkg::sample_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ptc_pkg::sample_t pop_data_o
);
  import ptc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sample_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
endmodule

FILE: sv/ptc_div.sv
`timescale 1ns / 1ps
// Bit-serial signed 64-bit divider, quotient truncated toward zero.
// Depends on ptc_pkg.
module ptc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptc_pkg::WordW-1:0] num_i,
  input  logic [ptc_pkg::WordW-1:0] den_i,
  output logic                      done_o,
  output logic [ptc_pkg::WordW-1:0] quo_o
);
  import ptc_pkg::*;

  localparam int CntW = $clog2(WordW + 1);

  logic [WordW-1:0] rem_q, quo_q, mb_q;
  logic             neg_q, busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [WordW:0]   sh;
  logic             fits;

  assign sh     = {rem_q, quo_q[WordW-1]};
  assign fits   = (sh >= {1'b0, mb_q});
  assign done_o = done_q;
  assign quo_o  = neg_q ? (WordW'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WordW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[WordW-1] ? (WordW'(0) - num_i) : num_i;
      mb_q  <= den_i[WordW-1] ? (WordW'(0) - den_i) : den_i;
      neg_q <= num_i[WordW-1] ^ den_i[WordW-1];
    end else if (busy_q) begin
      rem_q <= fits ? WordW'(sh - {1'b0, mb_q}) : sh[WordW-1:0];
      quo_q <= {quo_q[WordW-2:0], fits};
    end
  end
endmodule

FILE: sv/ptc_back.sv
`timescale 1ns / 1ps
// Compute back end: step sequencer around a shared 32x32 multiplier and the divider,
// plus the result register. Depends on ptc_pkg and ptc_div.
module ptc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptc_pkg::coeffs_t           coeffs_i,
  input  logic                       q_empty_i,
  input  ptc_pkg::sample_t           q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ptc_pkg::TempW-1:0] temperature_centi_o,
  output logic [ptc_pkg::PressW-1:0] pressure_q8_o,
  output logic                       pressure_valid_o
);
  import ptc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_e;

  localparam logic [3:0] StepLast = 4'd13;

  state_e           state_q, state_d;
  logic [3:0]       step_q;
  logic [1:0]       mc_q;
  sample_t          smp_q;
  logic [WordW-1:0] a_q, tmp_q, fine_q, v1_q, sq_q, v2_q, den_q, p_q;
  logic [WordW-1:0] pr_q;
  logic [31:0]      hi_q;
  logic [TempW-1:0] temp_q;
  logic [PressW-1:0] pout_q;
  logic             pvalid_q;

  logic             out_valid_q;
  logic [TempW-1:0] out_temp_q;
  logic [PressW-1:0] out_press_q;
  logic             out_pv_q;

  logic [WordW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [WordW-1:0] rt, rp, op_a, op_b, mr, q13, fine_n, tc, pf;
  logic [31:0]      mul_a, mul_b;
  logic [WordW-1:0] mul_p;
  logic             step_done, div_start, div_done, out_free;
  logic [WordW-1:0] div_quo;

  assign t1 = {48'd0, coeffs_i.temp_coeffs[15:0]};
  assign t2 = sx16(coeffs_i.temp_coeffs[31:16]);
  assign t3 = sx16(coeffs_i.temp_coeffs[47:32]);
  assign p1 = {48'd0, coeffs_i.press_low[15:0]};
  assign p2 = sx16(coeffs_i.press_low[31:16]);
  assign p3 = sx16(coeffs_i.press_low[47:32]);
  assign p4 = sx16(coeffs_i.press_low[63:48]);
  assign p5 = sx16(coeffs_i.press_high[15:0]);
  assign p6 = sx16(coeffs_i.press_high[31:16]);
  assign p7 = sx16(coeffs_i.press_high[47:32]);
  assign p8 = sx16(coeffs_i.press_high[63:48]);
  assign p9 = sx16(coeffs_i.press_last);

  assign rt  = {{(WordW-RawW){1'b0}}, smp_q.raw_temperature};
  assign rp  = {{(WordW-RawW){1'b0}}, smp_q.raw_pressure};
  assign q13 = WordW'($signed(p_q) >>> 13);

  always_comb begin
    op_a = v1_q;
    op_b = v1_q;
    case (step_q)
      4'd0:    begin op_a = (rt >> 3) - (t1 << 1); op_b = t2; end
      4'd1:    begin op_a = (rt >> 4) - t1; op_b = (rt >> 4) - t1; end
      4'd2:    begin op_a = tmp_q; op_b = t3; end
      4'd3:    begin op_a = fine_q; op_b = WordW'(5); end
      4'd4:    begin op_a = v1_q; op_b = v1_q; end
      4'd5:    begin op_a = sq_q; op_b = p6; end
      4'd6:    begin op_a = v1_q; op_b = p5; end
      4'd7:    begin op_a = sq_q; op_b = p3; end
      4'd8:    begin op_a = v1_q; op_b = p2; end
      4'd9:    begin op_a = tmp_q; op_b = p1; end
      4'd10:   begin op_a = ((WordW'(1048576) - rp) << 31) - v2_q; op_b = WordW'(3125); end
      4'd11:   begin op_a = p9; op_b = q13; end
      4'd12:   begin op_a = tmp_q; op_b = q13; end
      4'd13:   begin op_a = p8; op_b = p_q; end
      default: begin op_a = v1_q; op_b = v1_q; end
    endcase
  end

  // Wrapping 64-bit product from three 32x32 partial products, one per cycle.
  assign mul_a     = (mc_q == 2'd2) ? op_a[63:32] : op_a[31:0];
  assign mul_b     = (mc_q == 2'd1) ? op_b[63:32] : op_b[31:0];
  assign mul_p     = mul_a * mul_b;
  assign mr        = pr_q + {hi_q, 32'd0};
  assign step_done = (state_q == ST_MUL) && (mc_q == 2'd3);

  assign fine_n = a_q + WordW'($signed(mr) >>> 14);
  assign tc     = WordW'($signed(mr + WordW'(128)) >>> 8);
  assign pf     = WordW'($signed(p_q + a_q + tmp_q) >>> 8) + (p7 << 4);

  assign div_start = step_done && (step_q == 4'd10);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mr),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_MUL;
      ST_MUL: begin
        if (step_done) begin
          if (step_q == 4'd9 && WordW'($signed(mr) >>> 33) == '0) state_d = ST_PUSH;
          else if (step_q == 4'd10) state_d = ST_DIV;
          else if (step_q == StepLast) state_d = ST_ADD;
        end
      end
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_ADD:  state_d = ST_PUSH;
      ST_PUSH: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        step_q <= '0;
        mc_q   <= '0;
      end else if (state_q == ST_MUL) begin
        mc_q <= mc_q + 1'b1;
        if (step_done && step_q != StepLast) step_q <= step_q + 1'b1;
      end
      if (state_q == ST_PUSH && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) smp_q <= q_data_i;
    if (state_q == ST_MUL) begin
      case (mc_q)
        2'd0:    pr_q <= mul_p;
        2'd1:    hi_q <= mul_p[31:0];
        2'd2:    hi_q <= hi_q + mul_p[31:0];
        default: ;
      endcase
    end
    if (step_done) begin
      case (step_q)
        4'd0: a_q   <= WordW'($signed(mr) >>> 11);
        4'd1: tmp_q <= WordW'($signed(mr) >>> 12);
        4'd2: begin
          fine_q <= fine_n;
          v1_q   <= fine_n - WordW'(128000);
        end
        4'd3: begin
          if (tc[WordW-1]) temp_q <= ($signed(tc) < -64'sd32768) ? 16'h8000 : tc[15:0];
          else temp_q <= (tc > WordW'(32767)) ? 16'h7FFF : tc[15:0];
        end
        4'd4: sq_q  <= mr;
        4'd5: v2_q  <= mr;
        4'd6: v2_q  <= v2_q + (mr << 17) + (p4 << 35);
        4'd7: tmp_q <= WordW'($signed(mr) >>> 8);
        4'd8: tmp_q <= (WordW'(1) << 47) + tmp_q + (mr << 12);
        4'd9: begin
          den_q    <= WordW'($signed(mr) >>> 33);
          pout_q   <= '0;
          pvalid_q <= 1'b0;
        end
        4'd11: tmp_q <= mr;
        4'd12: a_q   <= WordW'($signed(mr) >>> 25);
        4'd13: tmp_q <= WordW'($signed(mr) >>> 19);
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done) p_q <= div_quo;
    if (state_q == ST_ADD) begin
      pvalid_q <= 1'b1;
      if (pf[WordW-1]) pout_q <= '0;
      else pout_q <= (pf > {{(WordW-PressW){1'b0}}, PressMax}) ? PressMax : pf[PressW-1:0];
    end
    if (state_q == ST_PUSH && out_free) begin
      out_temp_q  <= temp_q;
      out_press_q <= pout_q;
      out_pv_q    <= pvalid_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = $signed(out_temp_q);
  assign pressure_q8_o       = out_press_q;
  assign pressure_valid_o    = out_pv_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("back state not one-hot");
  a_div_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_DIV) else $error("divider started outside sequence");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("divider result with no waiter");
  a_push_pvalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) && !pvalid_q |-> pout_q == '0)
    else $error("pressure set on invalid result");
endmodule

FILE: sv/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
// Top level of the pressure/temperature compensation core: configuration registers,
// front, queue and compute back end. Depends on ptc_pkg, ptc_front, ptc_queue, ptc_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | sink      | in_valid_i/in_stall_o   | raw_pressure_i, raw_temperature_i
//   out     | source    | out_valid_o/out_stall_i | temperature_centi_o, pressure_q8_o,
//           |           |                     | pressure_valid_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Per sample the back end runs 14 products on the shared 32x32 multiplier, the bit-serial
// divider, and the IDLE, ADD and PUSH states, which pick up the sample, sum the pressure
// terms and load the result register. A sample with a zero pressure divisor skips the
// divider and the last four products.
// Reset clears the coefficients to zero and empties queue and result register.
// The input side keeps accepting beats while the queue has room; a stalled result
// holds in the output register while the back end works on the next sample.
module pressure_temperature_compensation_core #(
  parameter int QueueDepth = ptc_pkg::QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ptc_pkg::RawW-1:0]           raw_pressure_i,
  input  logic [ptc_pkg::RawW-1:0]           raw_temperature_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ptc_pkg::TempW-1:0]   temperature_centi_o,
  output logic [ptc_pkg::PressW-1:0]         pressure_q8_o,
  output logic                               pressure_valid_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ptc_pkg::WordW-1:0]          cfg_data_i
);
  import ptc_pkg::*;

  coeffs_t coeffs_q;
  sample_t q_in, q_out;
  logic    q_push, q_pop, q_full, q_empty;

  // Config writes land immediately; the port never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TEMP_COEFFS: coeffs_q.temp_coeffs <= cfg_data_i[47:0];
        REG_PRESS_LOW:   coeffs_q.press_low   <= cfg_data_i;
        REG_PRESS_HIGH:  coeffs_q.press_high  <= cfg_data_i;
        REG_PRESS_LAST:  coeffs_q.press_last  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Front: accept beats, drop no-sample markers.
  ptc_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_in)
  );

  ptc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  ptc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coeffs_i            (coeffs_q),
    .q_empty_i           (q_empty),
    .q_data_i            (q_out),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_q8_o       (pressure_q8_o),
    .pressure_valid_o    (pressure_valid_o)
  );
endmodule
